@@ hw/rtl/tcgw_pkg.sv @@
// Shared types, constants and codes for the text console glyph writer.
`default_nettype none

package tcgw_pkg;

  localparam int GLYPH_COUNT = 96;
  localparam int GLYPH_ROWS  = 16;
  localparam int CELL_WIDTH  = 8;

  localparam int COORD_W  = 12;
  localparam int COLOR_W  = 24;
  localparam int BITS_W   = 8;
  localparam int GIDX_W   = 7;
  localparam int GROW_W   = 4;
  localparam int CODE_W   = 8;
  localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
  localparam int FONT_AW  = GIDX_W + GROW_W;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_COLOR = 2'd2;

  localparam logic [COORD_W-1:0] RESET_SCREEN_WIDTH  = 12'd1280;
  localparam logic [COORD_W-1:0] RESET_SCREEN_HEIGHT = 12'd720;
  localparam logic [COLOR_W-1:0] RESET_BACKGROUND    = 24'h0D1117;

  localparam logic [COORD_W-1:0] TAB_MAX    = 12'd4032;
  localparam logic [CODE_W-1:0]  FIRST_CODE = 8'd32;
  localparam logic [CODE_W-1:0]  LAST_CODE  = 8'd127;
  localparam logic [CODE_W-1:0]  SUBST_CODE = 8'h3F;

  localparam logic [CODE_W-1:0] CODE_TAB     = 8'd9;
  localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'd10;
  localparam logic [CODE_W-1:0] CODE_RETURN  = 8'd13;

  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_SCROLL = 1'b1;

  typedef struct packed {
    logic               func;
    logic [CODE_W-1:0]  char_code;
    logic [COLOR_W-1:0] fg_color;
    logic [GIDX_W-1:0]  glyph_index;
    logic [GROW_W-1:0]  glyph_row;
    logic [BITS_W-1:0]  row_pattern;
  } req_t;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [BITS_W-1:0]  pixel_bits;
    logic [COLOR_W-1:0] draw_fg;
    logic [COLOR_W-1:0] draw_bg;
    logic               last;
  } res_t;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_NEWLINE,
    OP_RETURN,
    OP_TAB,
    OP_CHAR
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROWS,
    ST_SCROLL
  } state_t;

  typedef struct packed {
    logic load_font;
    logic newline;
    logic ret;
    logic tab;
    logic start_char;
    logic emit_row;
    logic finish_char;
    logic emit_scroll;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic row_last;
    logic wrap;
    logic nl_scroll;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ hw/rtl/tcgw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcgw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tcgw_ctrl.sv @@
// Controller state machine: sequences font loads, cursor moves, glyph rows and scrolls.
`default_nettype none

module tcgw_ctrl
  import tcgw_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    req_valid,
  output logic         req_stall,
  input  wire status_t st,
  output cmd_t         cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (st.op == OP_CHAR) begin
            state_next = ST_ROWS;
          end else if (st.op == OP_NEWLINE && st.nl_scroll) begin
            state_next = ST_SCROLL;
          end
        end
      end
      ST_ROWS: begin
        if (st.out_free && st.row_last) begin
          state_next = (st.wrap && st.nl_scroll) ? ST_SCROLL : ST_IDLE;
        end
      end
      ST_SCROLL: begin
        if (st.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        // hold off requests while in reset
        req_stall = rst;
        if (req_valid && !rst) begin
          unique case (st.op)
            OP_LOAD:    cmd.load_font  = 1'b1;
            OP_NEWLINE: cmd.newline    = 1'b1;
            OP_RETURN:  cmd.ret        = 1'b1;
            OP_TAB:     cmd.tab        = 1'b1;
            OP_CHAR:    cmd.start_char = 1'b1;
            default:    cmd            = '0;
          endcase
        end
      end
      ST_ROWS: begin
        if (st.out_free) begin
          cmd.emit_row    = 1'b1;
          cmd.finish_char = st.row_last;
        end
      end
      ST_SCROLL: begin
        cmd.emit_scroll = st.out_free;
      end
      default: req_stall = 1'b1;
    endcase
  end

  a_row_needs_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_row || cmd.emit_scroll) |-> st.out_free)
    else $error("result issued into a full output register");

  a_char_enters_rows: assert property (@(posedge clk) disable iff (rst)
    cmd.start_char |=> (state == ST_ROWS))
    else $error("character request did not start the row sequence");

endmodule

`default_nettype wire

@@ hw/rtl/tcgw_dpath.sv @@
// Datapath: config registers, cursor, row counter, font store and result register.
`default_nettype none

module tcgw_dpath
  import tcgw_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire req_t                 req,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COLOR_W-1:0]   cfg_data,
  input  wire cmd_t                 cmd,
  output status_t                   st,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output res_t                      res
);

  logic [COORD_W-1:0] screen_width;
  logic [COORD_W-1:0] screen_height;
  logic [COLOR_W-1:0] background_color;
  logic [COORD_W-1:0] cursor_column;
  logic [COORD_W-1:0] cursor_row;
  logic [GROW_W-1:0]  row_cnt;
  logic [GIDX_W-1:0]  glyph_sel;
  logic [COLOR_W-1:0] fg_hold;

  logic [GIDX_W-1:0]  req_glyph;
  logic [CODE_W-1:0]  code_off;
  logic [COORD_W+1:0] col_step;
  logic [COORD_W+1:0] row_down;
  logic [COORD_W:0]   tab_sum;
  logic [COORD_W-1:0] col_tab;
  logic [COORD_W-1:0] row_pinned;
  logic [COORD_W-1:0] row_nl;
  logic               wrap;
  logic               nl_scroll;
  logic               row_last;
  logic               out_free;

  logic               ram_we;
  logic [FONT_AW-1:0] ram_waddr;
  logic               ram_re;
  logic [FONT_AW-1:0] ram_raddr;
  logic [BITS_W-1:0]  ram_rdata;

  // Glyph slot for a printable code; anything else shows the substitute glyph.
  always_comb begin
    if (req.char_code < FIRST_CODE || req.char_code > LAST_CODE) begin
      code_off = SUBST_CODE - FIRST_CODE;
    end else begin
      code_off = req.char_code - FIRST_CODE;
    end
    req_glyph = code_off[GIDX_W-1:0];
  end

  always_comb begin
    if (req.func == FUNC_LOAD) begin
      st.op = OP_LOAD;
    end else if (req.char_code == CODE_NEWLINE) begin
      st.op = OP_NEWLINE;
    end else if (req.char_code == CODE_RETURN) begin
      st.op = OP_RETURN;
    end else if (req.char_code == CODE_TAB) begin
      st.op = OP_TAB;
    end else begin
      st.op = OP_CHAR;
    end
    st.row_last  = row_last;
    st.wrap      = wrap;
    st.nl_scroll = nl_scroll;
    st.out_free  = out_free;
  end

  always_comb begin
    col_step   = {2'b00, cursor_column} + 14'(CELL_WIDTH);
    wrap       = (col_step + 14'(CELL_WIDTH)) > {2'b00, screen_width};
    row_down   = {2'b00, cursor_row} + 14'(GLYPH_ROWS);
    nl_scroll  = (row_down + 14'(GLYPH_ROWS)) > {2'b00, screen_height};
    row_pinned = (screen_height >= 12'(GLYPH_ROWS)) ?
                 screen_height - 12'(GLYPH_ROWS) : '0;
    row_nl     = nl_scroll ? row_pinned : row_down[COORD_W-1:0];
    tab_sum    = ({1'b0, cursor_column} + 13'd64) & ~13'd63;
    col_tab    = (tab_sum > {1'b0, TAB_MAX}) ? TAB_MAX : tab_sum[COORD_W-1:0];
    row_last   = (row_cnt == GROW_W'(GLYPH_ROWS - 1));
    out_free   = !res_valid || !res_stall;
  end

  // Font store port control.
  always_comb begin
    ram_we    = cmd.load_font && (req.glyph_index < GIDX_W'(GLYPH_COUNT));
    ram_waddr = {req.glyph_index, req.glyph_row};
    ram_re    = cmd.start_char || (cmd.emit_row && !row_last);
    if (cmd.start_char) begin
      ram_raddr = {req_glyph, {GROW_W{1'b0}}};
    end else begin
      ram_raddr = {glyph_sel, row_cnt + 1'b1};
    end
  end

  tcgw_ram #(
    .WIDTH (BITS_W),
    .DEPTH (FONT_DEPTH)
  ) u_font (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req.row_pattern),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width     <= RESET_SCREEN_WIDTH;
      screen_height    <= RESET_SCREEN_HEIGHT;
      background_color <= RESET_BACKGROUND;
      cursor_column    <= '0;
      cursor_row       <= '0;
      row_cnt          <= '0;
      res_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SCREEN_WIDTH:     screen_width     <= cfg_data[COORD_W-1:0];
          CFG_SCREEN_HEIGHT:    screen_height    <= cfg_data[COORD_W-1:0];
          CFG_BACKGROUND_COLOR: background_color <= cfg_data;
          default:              ;
        endcase
      end

      if (cmd.newline || (cmd.finish_char && wrap)) begin
        cursor_column <= '0;
        cursor_row    <= row_nl;
      end else if (cmd.finish_char) begin
        cursor_column <= col_step[COORD_W-1:0];
      end else if (cmd.ret) begin
        cursor_column <= '0;
      end else if (cmd.tab) begin
        cursor_column <= col_tab;
      end

      if (cmd.start_char) begin
        row_cnt <= '0;
      end else if (cmd.emit_row) begin
        row_cnt <= row_cnt + 1'b1;
      end

      if (cmd.emit_row || cmd.emit_scroll) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers: hold the request context and the pending result.
  always_ff @(posedge clk) begin
    if (cmd.start_char) begin
      glyph_sel <= req_glyph;
      fg_hold   <= req.fg_color;
    end
    if (cmd.emit_row) begin
      res.kind       <= KIND_DRAW;
      res.pixel_x    <= cursor_column;
      res.pixel_y    <= cursor_row + {{(COORD_W-GROW_W){1'b0}}, row_cnt};
      res.pixel_bits <= ram_rdata;
      res.draw_fg    <= fg_hold;
      res.draw_bg    <= background_color;
      res.last       <= row_last && !(wrap && nl_scroll);
    end else if (cmd.emit_scroll) begin
      res.kind       <= KIND_SCROLL;
      res.pixel_x    <= '0;
      res.pixel_y    <= cursor_row;
      res.pixel_bits <= '0;
      res.draw_fg    <= '0;
      res.draw_bg    <= background_color;
      res.last       <= 1'b1;
    end
  end

  a_scroll_is_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == KIND_SCROLL) |-> res.last)
    else $error("scroll result not marked last");

  a_issue_shows: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_row || cmd.emit_scroll) |=> res_valid)
    else $error("issued result not presented");

endmodule

`default_nettype wire

@@ hw/rtl/text_console_glyph_writer.sv @@
// Top level of the text console glyph writer: controller, datapath and font store.
//
// Usage:
//   Request channel (req_valid / req_stall / req): one request either loads
//   one 8-bit row of one glyph into the font store (func = 1) or puts one
//   character (func = 0). Result channel (res_valid / res_stall / res)
//   carries glyph-row draws and scroll commands; last marks the final
//   result of a request. Configuration: cfg_we writes cfg_data into the
//   register at cfg_index (0 width, 1 height, 2 background color); write
//   only while the block is idle.
//   Sequencing: font loads, carriage return, tab and a newline without scroll
//   finish on acceptance. A printable character starts the first font store
//   read on acceptance; the single read port then delivers one glyph row per
//   cycle unless the result channel stalls, each row passing from the font
//   store read register into the result register. A scroll adds a scroll result.
//   Reset clears the cursor to the top left and loads the default screen
//   size and background; the font store is undefined until loaded.
//   A stall on the result channel holds the result register and pauses
//   the row sequence; a new request is taken while the last result waits.
`default_nettype none

module text_console_glyph_writer
  import tcgw_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire req_t                 req,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output res_t                      res,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COLOR_W-1:0]   cfg_data
);

  cmd_t    cmd;
  status_t st;

  tcgw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .st        (st),
    .cmd       (cmd)
  );

  tcgw_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

`default_nettype wire
